// ===== sv/turtle_path_interpreter_defines.svh =====
// Assertion macros for the turtle path interpreter.
// Included by the RTL file that carries concurrent assertions; no dependencies.
`ifndef TURTLE_PATH_INTERPRETER_DEFINES_SVH
`define TURTLE_PATH_INTERPRETER_DEFINES_SVH

`ifndef SYNTHESIS
`define TPI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define TPI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define TPI_ASSERT(label, clk, rst_n, prop)
`define TPI_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== sv/tpi_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the turtle path interpreter.
// No dependencies.
package tpi_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
    localparam int SINE_DEPTH      = 1 << QTR_BITS;
    localparam int SINE_STEP_SHIFT = 16 - SINE_TABLE_BITS;
    localparam int PADDR_W         = 5;

    localparam logic [7:0] SYM_FWD   = 8'h66;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_START_HEADING = 3'd0,
        REG_TURN_STEP     = 3'd1,
        REG_STEP_LENGTH   = 3'd2,
        REG_START_X       = 3'd3,
        REG_START_Y       = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        start_heading;
        logic [15:0]        turn_step;
        logic [30:0]        step_length;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_heading: 16'd16384,
        turn_step:     16'd16384,
        step_length:   31'd65536,
        start_x:       32'sd0,
        start_y:       32'sd0
    };

    // sign and Q16 magnitude (0..65536) of a sine or cosine
    typedef struct packed {
        logic        neg;
        logic [16:0] mag;
    } trig_t;

    typedef logic [16:0] sine_tab_t [SINE_DEPTH];

    // Q30 odd polynomial, Horner, every product truncated; rounded to Q16
    function automatic logic [16:0] quarter_sine(input longint unsigned x);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned p;
        longint unsigned r;
        t  = x << 16;
        t2 = (t * t) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995    - ((p * t2) >> 30);
        p  = 64'd85569310   - ((p * t2) >> 30);
        p  = 64'd693598680  - ((p * t2) >> 30);
        p  = 64'd1686629713 - ((p * t2) >> 30);
        r  = (((p * t) >> 30) + 64'd8192) >> 14;
        if (r > 64'd65536)
        begin
            r = 64'd65536;
        end
        return r[16:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            tab[k] = quarter_sine(64'(k) << SINE_STEP_SHIFT);
        end
        return tab;
    endfunction

    localparam sine_tab_t   SINE_TAB  = build_sine_tab();
    localparam logic [16:0] SINE_PEAK = quarter_sine(64'd16384);

endpackage

// ===== sv/tpi_if.sv =====
// Handshake channels of the turtle path interpreter: symbol requests in, segments out.
// No dependencies.
interface tpi_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       restart;

    modport source (output valid, output symbol, output restart, input ready);
    modport sink   (input valid, input symbol, input restart, output ready);
endinterface

interface tpi_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seg_x0;
    logic signed [31:0] seg_y0;
    logic signed [31:0] seg_x1;
    logic signed [31:0] seg_y1;

    modport source (output valid, output seg_x0, output seg_y0, output seg_x1,
                    output seg_y1, input ready);
    modport sink   (input valid, input seg_x0, input seg_y0, input seg_x1,
                    input seg_y1, output ready);
endinterface

// ===== sv/tpi_cfg_regs.sv =====
// APB-style configuration register file of the turtle path interpreter.
// Depends on tpi_pkg.
module tpi_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output tpi_pkg::cfg_t               cfg
);
    import tpi_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    always_comb
    begin
        idx      = reg_idx_t'(paddr[PADDR_W-1:2]);
        wr_en    = psel && penable && pwrite;
        cfg_next = cfg_reg;
        prdata   = '0;
        case (idx)
            REG_START_HEADING:
            begin
                prdata = {16'd0, cfg_reg.start_heading};
                if (wr_en) cfg_next.start_heading = pwdata[15:0];
            end
            REG_TURN_STEP:
            begin
                prdata = {16'd0, cfg_reg.turn_step};
                if (wr_en) cfg_next.turn_step = pwdata[15:0];
            end
            REG_STEP_LENGTH:
            begin
                prdata = {1'b0, cfg_reg.step_length};
                if (wr_en) cfg_next.step_length = pwdata[30:0];
            end
            REG_START_X:
            begin
                prdata = cfg_reg.start_x;
                if (wr_en) cfg_next.start_x = pwdata;
            end
            REG_START_Y:
            begin
                prdata = cfg_reg.start_y;
                if (wr_en) cfg_next.start_y = pwdata;
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// ===== sv/tpi_trig.sv =====
// Cosine and sine of the quantized heading from the quarter-wave table.
// Depends on tpi_pkg.
module tpi_trig (
    input  logic [15:0]    heading,
    output tpi_pkg::trig_t cos_val,
    output tpi_pkg::trig_t sin_val
);
    import tpi_pkg::*;

    typedef logic [SINE_TABLE_BITS-1:0] phase_t;

    localparam phase_t QTR_TURN = phase_t'(SINE_DEPTH);

    function automatic trig_t fold(input phase_t p);
        logic [QTR_BITS-1:0] x;
        logic [QTR_BITS-1:0] idx;
        trig_t               r;
        x     = p[QTR_BITS-1:0];
        idx   = p[QTR_BITS] ? QTR_BITS'(0) - x : x;
        r.neg = p[SINE_TABLE_BITS-1];
        r.mag = (p[QTR_BITS] && x == '0) ? SINE_PEAK : SINE_TAB[idx];
        return r;
    endfunction

    phase_t ph;

    always_comb
    begin
        ph      = heading[15 -: SINE_TABLE_BITS];
        sin_val = fold(ph);
        cos_val = fold(ph + QTR_TURN);
    end

endmodule

// ===== sv/tpi_move.sv =====
// One axis of a forward step: length times trig value, rounded, saturating add.
// Depends on tpi_pkg.
module tpi_move (
    input  logic signed [31:0] pos,
    input  logic [30:0]        step_length,
    input  tpi_pkg::trig_t     trig,
    output logic signed [31:0] pos_new
);
    import tpi_pkg::*;

    logic [47:0] prod;
    logic [30:0] delta;
    logic [32:0] sum;

    always_comb
    begin
        prod  = 48'(step_length) * 48'(trig.mag) + 48'd32768;
        delta = prod[46:16];
        if (trig.neg)
        begin
            sum = {pos[31], pos} - {2'b00, delta};
        end
        else
        begin
            sum = {pos[31], pos} + {2'b00, delta};
        end
        if (sum[32] != sum[31])
        begin
            pos_new = sum[32] ? POS_MIN : POS_MAX;
        end
        else
        begin
            pos_new = sum[31:0];
        end
    end

endmodule

// ===== sv/turtle_path_interpreter.sv =====
// Turtle path interpreter: L-system symbols in, line segments out.
// Depends on tpi_pkg, tpi_if, tpi_cfg_regs, tpi_trig, tpi_move.
//
// Usage:
//   sym_in  : one request per symbol with a restart flag; restart reloads heading
//             and position from the start registers before the symbol is handled.
//   seg_out : one segment per 'f' symbol (start and end point, Q16.16).
//             '+' and '-' turn the heading; every other symbol is dropped silently.
//   APB     : five registers at 4-byte spacing, written with the block idle;
//             start values take effect at the next restart.
// Throughput: one symbol per cycle while seg_out takes segments. A request waits in the
//   input register; the heading update, table lookup, multiply and saturating add run
//   combinationally from it, and a segment is registered into the output register.
// Reset: turtle state and registers return to their reset values, both
//   pipeline registers are emptied.
// Stall: while a segment waits on seg_out, non-drawing symbols keep flowing;
//   an 'f' waits in the input register, and sym_in.ready drops only then.
`include "turtle_path_interpreter_defines.svh"

module turtle_path_interpreter (
    input  logic                        clk,
    input  logic                        rst_n,
    tpi_sym_if.sink                     sym_in,
    tpi_seg_if.source                   seg_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tpi_pkg::*;

    cfg_t cfg;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         sym_reg;
    logic               restart_reg;

    logic [15:0]        heading_reg;
    logic [15:0]        heading_next;
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_x_next;
    logic signed [31:0] pos_y_reg;
    logic signed [31:0] pos_y_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] seg_x0_reg;
    logic signed [31:0] seg_y0_reg;
    logic signed [31:0] seg_x1_reg;
    logic signed [31:0] seg_y1_reg;

    logic [15:0]        cur_heading;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    trig_t              cos_val;
    trig_t              sin_val;
    logic               sym_is_f;
    logic               out_free;
    logic               advance;
    logic               in_take;

    tpi_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpi_trig u_trig (
        .heading (cur_heading),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    tpi_move u_move_x (
        .pos         (cur_x),
        .step_length (cfg.step_length),
        .trig        (cos_val),
        .pos_new     (new_x)
    );

    tpi_move u_move_y (
        .pos         (cur_y),
        .step_length (cfg.step_length),
        .trig        (sin_val),
        .pos_new     (new_y)
    );

    always_comb
    begin
        sym_is_f     = (sym_reg == SYM_FWD);
        out_free     = !out_valid_reg || seg_out.ready;
        advance      = in_valid_reg && (!sym_is_f || out_free);
        sym_in.ready = !in_valid_reg || advance;
        in_take      = sym_in.valid && sym_in.ready;

        cur_heading  = restart_reg ? cfg.start_heading : heading_reg;
        cur_x        = restart_reg ? cfg.start_x : pos_x_reg;
        cur_y        = restart_reg ? cfg.start_y : pos_y_reg;

        case (sym_reg)
            SYM_PLUS:  heading_next = cur_heading + cfg.turn_step;
            SYM_MINUS: heading_next = cur_heading - cfg.turn_step;
            default:   heading_next = cur_heading;
        endcase
        pos_x_next = sym_is_f ? new_x : cur_x;
        pos_y_next = sym_is_f ? new_y : cur_y;

        in_valid_next  = in_take || (in_valid_reg && !advance);
        out_valid_next = (advance && sym_is_f) || (out_valid_reg && !seg_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            heading_reg   <= CFG_RESET.start_heading;
            pos_x_reg     <= CFG_RESET.start_x;
            pos_y_reg     <= CFG_RESET.start_y;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                heading_reg <= heading_next;
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sym_reg     <= sym_in.symbol;
            restart_reg <= sym_in.restart;
        end
        if (advance && sym_is_f)
        begin
            seg_x0_reg <= cur_x;
            seg_y0_reg <= cur_y;
            seg_x1_reg <= new_x;
            seg_y1_reg <= new_y;
        end
    end

    assign seg_out.valid  = out_valid_reg;
    assign seg_out.seg_x0 = seg_x0_reg;
    assign seg_out.seg_y0 = seg_y0_reg;
    assign seg_out.seg_x1 = seg_x1_reg;
    assign seg_out.seg_y1 = seg_y1_reg;

    // a pending segment is never overwritten
    `TPI_ASSERT(a_no_overwrite, clk, rst_n, out_valid_reg && !seg_out.ready |-> !(advance && sym_is_f))
    `TPI_ASSERT(a_seg_loaded, clk, rst_n, advance && sym_is_f |=> out_valid_reg)
    `TPI_ASSERT(a_state_hold, clk, rst_n, !advance |=> $stable(heading_reg) && $stable(pos_x_reg) && $stable(pos_y_reg))
    `TPI_ASSERT(a_pos_hold, clk, rst_n, advance && !sym_is_f && !restart_reg |=> $stable(pos_x_reg) && $stable(pos_y_reg))
    `TPI_ASSERT_ALWAYS(a_empty_ready, clk, !in_valid_reg |-> sym_in.ready)

endmodule

// ===== dv/turtle_path_interpreter_tb.sv =====
// Testbench for turtle_path_interpreter: drives symbol requests and APB register writes,
// predicts each segment and checks it field by field. Depends on tpi_pkg, tpi_if and the RTL.
module turtle_path_interpreter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpi_pkg::*;

    localparam int          HEADING_DROP = 16 - SINE_TABLE_BITS;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASES       = 11;
    localparam int          PHASE_ITEMS  = 150;
    localparam logic [2:0]  REG_SPARE_LO = 3'd5;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
    } seg_t;

    typedef struct {
        bit   pinned;
        seg_t seg;
    } pin_t;

    typedef enum bit {ROW_SYM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  sym;
        logic        rst;
        bit          pinned;
        seg_t        seg;
        logic [2:0]  idx;
        logic [31:0] data;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tpi_sym_if sym_bus();
    tpi_seg_if seg_bus();

    turtle_path_interpreter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sym_in  (sym_bus),
        .seg_out (seg_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // turtle shadow
    cfg_t               regs_shadow = CFG_RESET;
    logic [15:0]        heading_now = CFG_RESET.start_heading;
    logic signed [31:0] at_x        = CFG_RESET.start_x;
    logic signed [31:0] at_y        = CFG_RESET.start_y;

    seg_t      segs_due[$];
    pin_t      pins_due[$];
    plan_row_t plan[$];
    int        n_mismatch = 0;
    int        cycles     = 0;
    bit        quiet      = 0;

    function automatic longint unsigned quarter_wave(input longint unsigned x);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned acc;
        longint unsigned r;
        t   = x << 16;
        t2  = (t * t) >> 30;
        acc = 64'd172272;
        acc = 64'd5026995    - ((acc * t2) >> 30);
        acc = 64'd85569310   - ((acc * t2) >> 30);
        acc = 64'd693598680  - ((acc * t2) >> 30);
        acc = 64'd1686629713 - ((acc * t2) >> 30);
        r   = (((acc * t) >> 30) + 64'd8192) >> 14;
        return (r > 64'd65536) ? 64'd65536 : r;
    endfunction

    function automatic int signed_sine(input logic [15:0] ph);
        logic [13:0]     frac;
        longint unsigned m;
        frac = ph[13:0];
        m = ph[14] ? quarter_wave(64'd16384 - 64'(frac)) : quarter_wave(64'(frac));
        return ph[15] ? -int'(m) : int'(m);
    endfunction

    function automatic longint scaled_step(input logic [30:0] len, input int trig);
        longint unsigned mag;
        longint unsigned d;
        mag = (trig < 0) ? 64'(-trig) : 64'(trig);
        d = (64'(len) * mag + 64'd32768) >> 16;
        return (trig < 0) ? -longint'(d) : longint'(d);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(POS_MAX))
        begin
            return POS_MAX;
        end
        if (v < longint'(POS_MIN))
        begin
            return POS_MIN;
        end
        return v[31:0];
    endfunction

    function automatic void advance_turtle(input logic [7:0] sym, input logic rst,
                                           output seg_t seg, output bit drew);
        logic [15:0] ph;
        int          cos_q;
        int          sin_q;
        drew = 0;
        seg  = '0;
        if (rst)
        begin
            heading_now = regs_shadow.start_heading;
            at_x        = regs_shadow.start_x;
            at_y        = regs_shadow.start_y;
        end
        case (sym)
            SYM_FWD:
            begin
                ph     = (heading_now >> HEADING_DROP) << HEADING_DROP;
                cos_q  = signed_sine(ph + 16'd16384);
                sin_q  = signed_sine(ph);
                seg.x0 = at_x;
                seg.y0 = at_y;
                seg.x1 = clamp32(longint'(at_x) + scaled_step(regs_shadow.step_length, cos_q));
                seg.y1 = clamp32(longint'(at_y) + scaled_step(regs_shadow.step_length, sin_q));
                at_x   = seg.x1;
                at_y   = seg.y1;
                drew   = 1;
            end
            SYM_PLUS:  heading_now = heading_now + regs_shadow.turn_step;
            SYM_MINUS: heading_now = heading_now - regs_shadow.turn_step;
            default: ;
        endcase
    endfunction

    function automatic void record_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_START_HEADING: regs_shadow.start_heading = data[15:0];
            REG_TURN_STEP:     regs_shadow.turn_step     = data[15:0];
            REG_STEP_LENGTH:   regs_shadow.step_length   = data[30:0];
            REG_START_X:       regs_shadow.start_x       = data;
            REG_START_Y:       regs_shadow.start_y       = data;
            default: ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (want !== got)
        begin
            flag_mismatch($sformatf("%s expected %08h got %08h", name, want, got));
        end
    endfunction

    function automatic plan_row_t sym_row(input logic [7:0] sym, input logic rst);
        plan_row_t row;
        row.kind   = ROW_SYM;
        row.sym    = sym;
        row.rst    = rst;
        row.pinned = 0;
        row.seg    = '0;
        row.idx    = '0;
        row.data   = '0;
        return row;
    endfunction

    function automatic plan_row_t pinned_row(input logic rst, input logic signed [31:0] x0,
                                             input logic signed [31:0] y0,
                                             input logic signed [31:0] x1,
                                             input logic signed [31:0] y1);
        plan_row_t row;
        row        = sym_row(SYM_FWD, rst);
        row.pinned = 1;
        row.seg    = '{x0: x0, y0: y0, x1: x1, y1: y1};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
        plan_row_t row;
        row      = sym_row(8'h00, 1'b0);
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // scoreboard
    always @(posedge clk)
    begin
        seg_t got;
        seg_t want;
        seg_t seg;
        bit   drew;
        pin_t pin;
        if (rst_n && seg_bus.valid && seg_bus.ready)
        begin
            got = '{x0: seg_bus.seg_x0, y0: seg_bus.seg_y0,
                    x1: seg_bus.seg_x1, y1: seg_bus.seg_y1};
            if (segs_due.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected segment %h", got));
            end
            else
            begin
                want = segs_due.pop_front();
                check_field("seg_x0", want.x0, got.x0);
                check_field("seg_y0", want.y0, got.y0);
                check_field("seg_x1", want.x1, got.x1);
                check_field("seg_y1", want.y1, got.y1);
            end
        end
        if (rst_n && sym_bus.valid && sym_bus.ready)
        begin
            pin = pins_due.pop_front();
            advance_turtle(sym_bus.symbol, sym_bus.restart, seg, drew);
            if (drew)
            begin
                segs_due.push_back(pin.pinned ? pin.seg : seg);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("turtle_path_interpreter: mismatch");
            $finish;
        end
    end

    // segment receiver with random stalls
    initial
    begin
        int stall;
        seg_bus.ready <= 1'b0;
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                seg_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            seg_bus.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rst_n && seg_bus.valid));
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input logic rst, input pin_t pin);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            sym_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pins_due.push_back(pin);
        sym_bus.valid   <= 1'b1;
        sym_bus.symbol  <= sym;
        sym_bus.restart <= rst;
        do
        begin
            @(posedge clk);
        end
        while (!sym_bus.ready);
    endtask

    task automatic settle();
        sym_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (segs_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        record_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_turn();
        case ($urandom_range(0, 4))
            0:       return {16'($urandom_range(0, 65535)), 16'h0001};
            1:       return {16'($urandom_range(0, 65535)), 16'h4000};
            2:       return {16'($urandom_range(0, 65535)), 16'hFFFF};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return {1'($urandom_range(0, 1)), 31'd0};
            1:       return {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
            2:       return $urandom();
            default: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0040_0000))};
        endcase
    endfunction

    initial
    begin
        pin_t       pin;
        logic [7:0] sym;
        logic       rst;
        int         pick;
        int         count;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        sym_bus.valid   <= 1'b0;
        sym_bus.symbol  <= '0;
        sym_bus.restart <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, turns, ignored symbols, saturation, zero step
        plan.push_back(pinned_row(1'b0, 0, 0, 0, 32'sd65536));
        plan.push_back(sym_row(SYM_FWD, 1'b0));
        plan.push_back(sym_row(SYM_PLUS, 1'b0));
        plan.push_back(sym_row(SYM_FWD, 1'b0));
        plan.push_back(sym_row(SYM_MINUS, 1'b0));
        plan.push_back(sym_row(SYM_MINUS, 1'b0));
        plan.push_back(sym_row(SYM_FWD, 1'b0));
        plan.push_back(sym_row(8'h5B, 1'b0));
        plan.push_back(sym_row(8'h5D, 1'b0));
        plan.push_back(sym_row(8'h00, 1'b0));
        plan.push_back(sym_row(8'hFF, 1'b1));
        plan.push_back(pinned_row(1'b1, 0, 0, 0, 32'sd65536));
        plan.push_back(cfg_row(REG_START_HEADING, 32'hFFFF_0000));
        plan.push_back(cfg_row(REG_STEP_LENGTH, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(REG_START_X, POS_MAX));
        plan.push_back(cfg_row(REG_TURN_STEP, 32'h0001_1234));
        plan.push_back(pinned_row(1'b1, POS_MAX, 0, POS_MAX, 0));
        plan.push_back(sym_row(SYM_PLUS, 1'b0));
        plan.push_back(sym_row(SYM_PLUS, 1'b0));
        plan.push_back(sym_row(SYM_MINUS, 1'b0));
        plan.push_back(sym_row(SYM_FWD, 1'b0));
        plan.push_back(cfg_row(REG_START_HEADING, 32'h0000_8000));
        plan.push_back(cfg_row(REG_START_X, POS_MIN));
        plan.push_back(cfg_row(REG_START_Y, POS_MIN));
        plan.push_back(pinned_row(1'b1, POS_MIN, POS_MIN, POS_MIN, POS_MIN));
        plan.push_back(cfg_row(REG_STEP_LENGTH, 32'h0000_0000));
        plan.push_back(cfg_row(REG_SPARE_LO, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(REG_SPARE_HI, 32'h5A5A_5A5A));
        plan.push_back(sym_row(SYM_MINUS, 1'b1));
        plan.push_back(pinned_row(1'b0, POS_MIN, POS_MIN, POS_MIN, POS_MIN));
        plan.push_back(sym_row(SYM_FWD, 1'b1));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                apb_write(plan[i].idx, plan[i].data);
            end
            else
            begin
                pin.pinned = plan[i].pinned;
                pin.seg    = plan[i].seg;
                send_symbol(plan[i].sym, plan[i].rst, pin);
            end
        end

        // random: a fresh register set per phase, then a random mix of drawing, turning and other symbols
        pin.pinned = 0;
        pin.seg    = '0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            quiet = (phase % 3 == 2);
            apb_write(REG_START_HEADING, $urandom());
            apb_write(REG_TURN_STEP, pick_turn());
            apb_write(REG_STEP_LENGTH, pick_length());
            apb_write(REG_START_X, pick_word());
            apb_write(REG_START_Y, pick_word());
            if ($urandom_range(0, 2) == 0)
            begin
                apb_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
            end
            count = 0;
            rst   = 1'($urandom_range(0, 1));
            while (count < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    sym = SYM_FWD;
                end
                else if (pick < 65)
                begin
                    sym = SYM_PLUS;
                end
                else if (pick < 85)
                begin
                    sym = SYM_MINUS;
                end
                else
                begin
                    sym = 8'($urandom_range(0, 255));
                end
                count++;
                send_symbol(sym, rst, pin);
                rst = ($urandom_range(0, 19) == 0);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (n_mismatch == 0 && segs_due.size() == 0)
        begin
            $display("turtle_path_interpreter: match");
        end
        else
        begin
            $display("turtle_path_interpreter: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tpi_pkg.sv
sv/tpi_if.sv
sv/tpi_cfg_regs.sv
sv/tpi_trig.sv
sv/tpi_move.sv
sv/turtle_path_interpreter.sv
dv/turtle_path_interpreter_tb.sv
